// File: rtl/core/cmb_pkg.sv
// cmb_pkg: widths, types, codes and saturating helpers for the cubic multibrot engine
// used by every module under rtl/core; depends on nothing else
`default_nettype none

package cmb_pkg;

  // field and arithmetic widths
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 30;
  localparam int ITER_BITS  = 16;
  localparam int WORD_BITS  = FRAC_BITS + 6;
  localparam int STEP_BITS  = WORD_BITS - 1;
  localparam int WIDE_BITS  = 2 * WORD_BITS;
  localparam int MAP_BITS   = COORD_BITS + STEP_BITS;
  localparam int HALF_BITS  = WORD_BITS / 2;
  localparam int HI_BITS    = WORD_BITS - HALF_BITS;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int RND_BITS   = PROD_BITS - FRAC_BITS;
  localparam int CFG_INDEX_BITS = 2;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // multiplier bookkeeping
  localparam int MUL_LATENCY = 4;
  localparam int OUTST_BITS  = $clog2(MUL_LATENCY + 2);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;
  typedef logic [COORD_BITS-1:0]       coord_t;
  typedef logic [ITER_BITS-1:0]        iter_t;
  typedef logic [STEP_BITS-1:0]        step_t;

  localparam word_t ORIGIN_RESET = word_t'(-(longint'(2) <<< FRAC_BITS));
  localparam step_t STEP_RESET   = STEP_BITS'(5368709);
  localparam iter_t ITER_RESET   = ITER_BITS'(64);

  localparam wide_t WORD_MAX_W   = (wide_t'(1) <<< (WORD_BITS - 1)) - wide_t'(1);
  localparam wide_t WORD_MIN_W   = -(wide_t'(1) <<< (WORD_BITS - 1));
  localparam wide_t ESCAPE_LIMIT = wide_t'(4) <<< FRAC_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ORIGIN_RE  = 2'd0,
    CFG_ORIGIN_IM  = 2'd1,
    CFG_PIXEL_STEP = 2'd2,
    CFG_MAX_ITER   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    word_t origin_re;
    word_t origin_im;
    step_t pixel_step;
    iter_t max_iter;
  } cfg_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
  } pix_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    iter_t  iter_count;
    logic   escaped;
    word_t  final_re;
    word_t  final_im;
  } res_t;

  // mapped request handed from front to back
  typedef struct packed {
    coord_t px;
    coord_t py;
    word_t  c_re;
    word_t  c_im;
  } qitem_t;

  typedef enum logic [2:0] {
    OP_RR  = 3'd0,
    OP_II  = 3'd1,
    OP_RRR = 3'd2,
    OP_RII = 3'd3,
    OP_RRI = 3'd4,
    OP_III = 3'd5
  } mul_op_t;

  typedef struct packed {
    logic    valid;
    mul_op_t op;
    word_t   a;
    word_t   b;
  } mul_req_t;

  typedef struct packed {
    logic    valid;
    mul_op_t op;
    word_t   p;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    BE_IDLE      = 4'd0,
    BE_CHECK     = 4'd1,
    BE_SQ        = 4'd2,
    BE_SQ_WAIT   = 4'd3,
    BE_TEST      = 4'd4,
    BE_CUBE_B    = 4'd5,
    BE_CUBE_C    = 4'd6,
    BE_CUBE_D    = 4'd7,
    BE_CUBE_WAIT = 4'd8,
    BE_COMB      = 4'd9,
    BE_ADD       = 4'd10,
    BE_DONE      = 4'd11
  } be_state_t;

  function automatic wide_t sx(input word_t v);
    return wide_t'(v);
  endfunction

  function automatic word_t sat_word(input wide_t v);
    word_t r;
    if (v > WORD_MAX_W) begin
      r = word_t'(WORD_MAX_W[WORD_BITS-1:0]);
    end else if (v < WORD_MIN_W) begin
      r = word_t'(WORD_MIN_W[WORD_BITS-1:0]);
    end else begin
      r = word_t'(v[WORD_BITS-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cmb_front.sv
// cmb_front: accepts pixel requests and maps them to the complex point c
// depends on cmb_pkg
`default_nettype none

module cmb_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cmb_pkg::cfg_t   cfg,
  input  wire logic            pix_valid,
  output logic                 pix_stall,
  input  wire cmb_pkg::pix_t   pix,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output cmb_pkg::qitem_t      push_item
);

  logic                          a_valid;
  cmb_pkg::coord_t               a_x;
  cmb_pkg::coord_t               a_y;
  logic [cmb_pkg::MAP_BITS-1:0]  a_pre;
  logic [cmb_pkg::MAP_BITS-1:0]  a_pim;
  logic [cmb_pkg::MAP_BITS-1:0]  pre;
  logic [cmb_pkg::MAP_BITS-1:0]  pim;
  cmb_pkg::wide_t                sum_re;
  cmb_pkg::wide_t                sum_im;
  logic                          b_valid;
  logic                          b_free;
  logic                          a_free;

  // coordinate times step, exact
  assign pre = pix.pixel_x * cfg.pixel_step;
  assign pim = pix.pixel_y * cfg.pixel_step;

  assign sum_re = cmb_pkg::sx(cfg.origin_re)
                + $signed({{(cmb_pkg::WIDE_BITS - cmb_pkg::MAP_BITS){1'b0}}, a_pre});
  assign sum_im = cmb_pkg::sx(cfg.origin_im)
                + $signed({{(cmb_pkg::WIDE_BITS - cmb_pkg::MAP_BITS){1'b0}}, a_pim});

  assign b_free     = !b_valid || push_ready;
  assign a_free     = !a_valid || b_free;
  assign pix_stall  = !a_free;
  assign push_valid = b_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= pix_valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && pix_valid) begin
      a_x   <= pix.pixel_x;
      a_y   <= pix.pixel_y;
      a_pre <= pre;
      a_pim <= pim;
    end
    if (b_free && a_valid) begin
      push_item.px   <= a_x;
      push_item.py   <= a_y;
      push_item.c_re <= cmb_pkg::sat_word(sum_re);
      push_item.c_im <= cmb_pkg::sat_word(sum_im);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cmb_queue.sv
// cmb_queue: short request queue between the front and back parts
// depends on cmb_pkg
`default_nettype none

module cmb_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire cmb_pkg::qitem_t  push_item,
  output logic                  pop_valid,
  input  wire logic             pop,
  output cmb_pkg::qitem_t       pop_item
);

  cmb_pkg::qitem_t               entries [cmb_pkg::QUEUE_DEPTH];
  logic [cmb_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [cmb_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [cmb_pkg::QCNT_BITS-1:0] count;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = count != cmb_pkg::QCNT_BITS'(cmb_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + cmb_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + cmb_pkg::QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + cmb_pkg::QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - cmb_pkg::QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cmb_fmul.sv
// cmb_fmul: four-stage saturating fixed-point multiplier, one product per cycle
// depends on cmb_pkg
`default_nettype none

module cmb_fmul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmb_pkg::mul_req_t req,
  output cmb_pkg::mul_rsp_t      rsp
);

  localparam int W = cmb_pkg::WORD_BITS;
  localparam int H = cmb_pkg::HALF_BITS;
  localparam logic [cmb_pkg::RND_BITS-1:0] NEG_LIM =
    cmb_pkg::RND_BITS'({1'b1, {(W - 1){1'b0}}});
  localparam logic [cmb_pkg::RND_BITS-1:0] POS_LIM = NEG_LIM - cmb_pkg::RND_BITS'(1);

  // stage 1: magnitudes and sign
  logic                   s1_valid;
  cmb_pkg::mul_op_t       s1_op;
  logic [W-1:0]           s1_ma;
  logic [W-1:0]           s1_mb;
  logic                   s1_neg;
  // stage 2: low partial product
  logic                   s2_valid;
  cmb_pkg::mul_op_t       s2_op;
  logic [W+H-1:0]         s2_pl;
  logic [W-1:0]           s2_ma;
  logic [cmb_pkg::HI_BITS-1:0] s2_mbh;
  logic                   s2_neg;
  // stage 3: full product, scaled
  logic                   s3_valid;
  cmb_pkg::mul_op_t       s3_op;
  logic [cmb_pkg::RND_BITS-1:0] s3_r;
  logic                   s3_neg;
  // stage 4: signed, saturated product
  logic                   rsp_valid;
  cmb_pkg::mul_op_t       rsp_op;
  cmb_pkg::word_t         rsp_p;

  logic [W-1:0]                     ma;
  logic [W-1:0]                     mb;
  logic [W+H-1:0]                   pl;
  logic [W+cmb_pkg::HI_BITS-1:0]    ph;
  logic [cmb_pkg::PROD_BITS-1:0]    full;
  logic [cmb_pkg::RND_BITS-1:0]     lim;
  logic [cmb_pkg::RND_BITS-1:0]     rc;
  logic [W-1:0]                     rw;

  assign ma   = req.a[W-1] ? (~req.a + W'(1)) : req.a;
  assign mb   = req.b[W-1] ? (~req.b + W'(1)) : req.b;
  assign pl   = s1_ma * s1_mb[H-1:0];
  assign ph   = s2_ma * s2_mbh;
  assign full = {{(cmb_pkg::PROD_BITS - W - H){1'b0}}, s2_pl}
              + {ph, {H{1'b0}}};
  assign lim  = s3_neg ? NEG_LIM : POS_LIM;
  assign rc   = (s3_r > lim) ? lim : s3_r;
  assign rw   = rc[W-1:0];

  always_comb begin
    rsp.valid = rsp_valid;
    rsp.op    = rsp_op;
    rsp.p     = rsp_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      s1_valid  <= req.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      rsp_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_op  <= req.op;
    s1_ma  <= ma;
    s1_mb  <= mb;
    s1_neg <= req.a[W-1] ^ req.b[W-1];

    s2_op  <= s1_op;
    s2_pl  <= pl;
    s2_ma  <= s1_ma;
    s2_mbh <= s1_mb[W-1:H];
    s2_neg <= s1_neg;

    s3_op  <= s2_op;
    s3_r   <= full[cmb_pkg::PROD_BITS-1:cmb_pkg::FRAC_BITS];
    s3_neg <= s2_neg;

    rsp_op <= s3_op;
    rsp_p  <= s3_neg ? cmb_pkg::word_t'(~rw + W'(1)) : cmb_pkg::word_t'(rw);
  end

endmodule

`default_nettype wire

// File: rtl/core/cmb_back.sv
// cmb_back: iteration sequencer for z = z^3 + c and the result register
// depends on cmb_pkg and drives one cmb_fmul through its request port
`default_nettype none

module cmb_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmb_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire cmb_pkg::qitem_t    q_item,
  output cmb_pkg::mul_req_t       mul_req,
  input  wire cmb_pkg::mul_rsp_t  mul_rsp,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output cmb_pkg::res_t           res
);

  cmb_pkg::be_state_t state;
  cmb_pkg::be_state_t state_next;

  cmb_pkg::coord_t cur_x;
  cmb_pkg::coord_t cur_y;
  cmb_pkg::word_t  cre;
  cmb_pkg::word_t  cim;
  cmb_pkg::word_t  zr;
  cmb_pkg::word_t  zi;
  cmb_pkg::word_t  zr2;
  cmb_pkg::word_t  zi2;
  cmb_pkg::word_t  p_rrr;
  cmb_pkg::word_t  p_rii;
  cmb_pkg::word_t  p_rri;
  cmb_pkg::word_t  p_iii;
  cmb_pkg::word_t  t_re;
  cmb_pkg::word_t  t_im;
  cmb_pkg::iter_t  iter;
  logic            esc;
  logic [cmb_pkg::OUTST_BITS-1:0] outstanding;

  logic            res_load;
  logic            escape_now;
  cmb_pkg::word_t  s3_rii;
  cmb_pkg::word_t  s3_rri;

  assign escape_now = (cmb_pkg::sx(zr2) + cmb_pkg::sx(zi2)) >= cmb_pkg::ESCAPE_LIMIT;
  assign s3_rii = cmb_pkg::sat_word((cmb_pkg::sx(p_rii) <<< 1) + cmb_pkg::sx(p_rii));
  assign s3_rri = cmb_pkg::sat_word((cmb_pkg::sx(p_rri) <<< 1) + cmb_pkg::sx(p_rri));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmb_pkg::BE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    res_load      = 1'b0;
    mul_req.valid = 1'b0;
    mul_req.op    = cmb_pkg::OP_RR;
    mul_req.a     = zr;
    mul_req.b     = zr;
    case (state)
      cmb_pkg::BE_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = cmb_pkg::BE_CHECK;
        end
      end
      cmb_pkg::BE_CHECK: begin
        if (iter < cfg.max_iter) begin
          mul_req.valid = 1'b1;
          state_next    = cmb_pkg::BE_SQ;
        end else begin
          state_next = cmb_pkg::BE_DONE;
        end
      end
      cmb_pkg::BE_SQ: begin
        mul_req.valid = 1'b1;
        mul_req.op    = cmb_pkg::OP_II;
        mul_req.a     = zi;
        mul_req.b     = zi;
        state_next    = cmb_pkg::BE_SQ_WAIT;
      end
      cmb_pkg::BE_SQ_WAIT: begin
        if (outstanding == '0) begin
          state_next = cmb_pkg::BE_TEST;
        end
      end
      cmb_pkg::BE_TEST: begin
        if (escape_now) begin
          state_next = cmb_pkg::BE_DONE;
        end else begin
          mul_req.valid = 1'b1;
          mul_req.op    = cmb_pkg::OP_RRR;
          mul_req.a     = zr2;
          mul_req.b     = zr;
          state_next    = cmb_pkg::BE_CUBE_B;
        end
      end
      cmb_pkg::BE_CUBE_B: begin
        mul_req.valid = 1'b1;
        mul_req.op    = cmb_pkg::OP_RII;
        mul_req.a     = zr;
        mul_req.b     = zi2;
        state_next    = cmb_pkg::BE_CUBE_C;
      end
      cmb_pkg::BE_CUBE_C: begin
        mul_req.valid = 1'b1;
        mul_req.op    = cmb_pkg::OP_RRI;
        mul_req.a     = zr2;
        mul_req.b     = zi;
        state_next    = cmb_pkg::BE_CUBE_D;
      end
      cmb_pkg::BE_CUBE_D: begin
        mul_req.valid = 1'b1;
        mul_req.op    = cmb_pkg::OP_III;
        mul_req.a     = zi2;
        mul_req.b     = zi;
        state_next    = cmb_pkg::BE_CUBE_WAIT;
      end
      cmb_pkg::BE_CUBE_WAIT: begin
        if (outstanding == '0) begin
          state_next = cmb_pkg::BE_COMB;
        end
      end
      cmb_pkg::BE_COMB: begin
        state_next = cmb_pkg::BE_ADD;
      end
      cmb_pkg::BE_ADD: begin
        state_next = cmb_pkg::BE_CHECK;
      end
      cmb_pkg::BE_DONE: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = cmb_pkg::BE_IDLE;
        end
      end
      default: begin
        state_next = cmb_pkg::BE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (mul_req.valid && !mul_rsp.valid) begin
        outstanding <= outstanding + cmb_pkg::OUTST_BITS'(1);
      end else if (mul_rsp.valid && !mul_req.valid) begin
        outstanding <= outstanding - cmb_pkg::OUTST_BITS'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // products land by tag
  always_ff @(posedge clk) begin
    if (mul_rsp.valid) begin
      case (mul_rsp.op)
        cmb_pkg::OP_RR:  zr2   <= mul_rsp.p;
        cmb_pkg::OP_II:  zi2   <= mul_rsp.p;
        cmb_pkg::OP_RRR: p_rrr <= mul_rsp.p;
        cmb_pkg::OP_RII: p_rii <= mul_rsp.p;
        cmb_pkg::OP_RRI: p_rri <= mul_rsp.p;
        cmb_pkg::OP_III: p_iii <= mul_rsp.p;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cmb_pkg::BE_IDLE: begin
        cur_x <= q_item.px;
        cur_y <= q_item.py;
        cre   <= q_item.c_re;
        cim   <= q_item.c_im;
        zr    <= '0;
        zi    <= '0;
        iter  <= '0;
        esc   <= 1'b0;
      end
      cmb_pkg::BE_TEST: begin
        esc <= escape_now;
      end
      cmb_pkg::BE_COMB: begin
        t_re <= cmb_pkg::sat_word(cmb_pkg::sx(p_rrr) - cmb_pkg::sx(s3_rii));
        t_im <= cmb_pkg::sat_word(cmb_pkg::sx(s3_rri) - cmb_pkg::sx(p_iii));
      end
      cmb_pkg::BE_ADD: begin
        zr   <= cmb_pkg::sat_word(cmb_pkg::sx(t_re) + cmb_pkg::sx(cre));
        zi   <= cmb_pkg::sat_word(cmb_pkg::sx(t_im) + cmb_pkg::sx(cim));
        iter <= iter + cmb_pkg::ITER_BITS'(1);
      end
      default: begin
      end
    endcase
    if (res_load) begin
      res.out_x      <= cur_x;
      res.out_y      <= cur_y;
      res.iter_count <= iter;
      res.escaped    <= esc;
      res.final_re   <= zr;
      res.final_im   <= zi;
    end
  end

  a_rsp_expected: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.valid |-> outstanding != '0)
    else $error("multiplier result with nothing outstanding");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == cmb_pkg::BE_IDLE || state == cmb_pkg::BE_DONE) |-> outstanding == '0)
    else $error("multiplier busy while sequencer idle or done");

  a_test_ready: assert property (@(posedge clk) disable iff (rst)
    (state == cmb_pkg::BE_TEST || state == cmb_pkg::BE_COMB) |-> outstanding == '0)
    else $error("products consumed before they landed");

  a_load_leaves: assert property (@(posedge clk) disable iff (rst)
    res_load |=> res_valid && state == cmb_pkg::BE_IDLE)
    else $error("result load did not present a result");

endmodule

`default_nettype wire

// File: rtl/core/cubic_multibrot_escape_time.sv
// cubic_multibrot_escape_time: top level, configuration registers and part wiring
// depends on cmb_pkg, cmb_front, cmb_queue, cmb_fmul and cmb_back
//
// usage
//   pixel channel: pix_valid / pix_stall carry one pixel request (pixel_x, pixel_y);
//   a request is taken at a clock edge with pix_valid high and pix_stall low
//   result channel: res_valid / res_stall carry one result per request, in order:
//   echoed coordinates, iteration count, escaped flag and the final z (Q5.30)
//   configuration: cfg_we with cfg_index and cfg_data writes origin_re, origin_im,
//   pixel_step or max_iter; the user must write only while no request is in flight,
//   which the block itself does not enforce
// datapath
//   the front end maps the pixel to c in its registered stages a and b and parks it
//   in a two-entry queue; the back end issues the cube products only once the
//   squares have come back through the four-stage shared multiplier
//   one pixel is iterated at a time
// reset
//   rst (synchronous) empties the queue and pipelines, drops res_valid and loads
//   origin -2 - 2i, step about 0.005 and a limit of 64
// back-pressure
//   a finished result waits in the output register while res_stall is high; the
//   back end holds its next result, the queue fills and pix_stall rises in turn
`default_nettype none

module cubic_multibrot_escape_time (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                pix_valid,
  output logic                                     pix_stall,
  input  wire cmb_pkg::pix_t                       pix,
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output cmb_pkg::res_t                            res,
  input  wire logic                                cfg_we,
  input  wire logic [cmb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [cmb_pkg::WORD_BITS-1:0]       cfg_data
);

  cmb_pkg::cfg_t      cfg;
  logic               push_valid;
  logic               push_ready;
  cmb_pkg::qitem_t    push_item;
  logic               q_valid;
  logic               q_pop;
  cmb_pkg::qitem_t    q_item;
  cmb_pkg::mul_req_t  mul_req;
  cmb_pkg::mul_rsp_t  mul_rsp;

  // configuration registers, written by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_re  <= cmb_pkg::ORIGIN_RESET;
      cfg.origin_im  <= cmb_pkg::ORIGIN_RESET;
      cfg.pixel_step <= cmb_pkg::STEP_RESET;
      cfg.max_iter   <= cmb_pkg::ITER_RESET;
    end else if (cfg_we) begin
      case (cmb_pkg::cfg_idx_t'(cfg_index))
        cmb_pkg::CFG_ORIGIN_RE:  cfg.origin_re  <= cmb_pkg::word_t'(cfg_data);
        cmb_pkg::CFG_ORIGIN_IM:  cfg.origin_im  <= cmb_pkg::word_t'(cfg_data);
        cmb_pkg::CFG_PIXEL_STEP: cfg.pixel_step <= cfg_data[cmb_pkg::STEP_BITS-1:0];
        cmb_pkg::CFG_MAX_ITER:   cfg.max_iter   <= cfg_data[cmb_pkg::ITER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and map to c
  cmb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix        (pix),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples mapping from iteration
  cmb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // shared multiplier for all six products of an iteration
  cmb_fmul u_fmul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // back: iteration sequencer and result register
  cmb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire
